// ----- rtl/r2i_pkg.sv -----
// Shared types and constants for the RGB to I420 converter.
package r2i_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W     = 13;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int COMP_W    = 8;
    localparam int ADDR_W    = 25;
    localparam int PLANE_W   = 2;
    localparam int Q_DEPTH   = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // register index codes, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    typedef struct packed {
        logic             wr;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              chroma;
        logic [ADDR_W-1:0] luma_addr;
        logic [ADDR_W-1:0] u_addr;
        logic [ADDR_W-1:0] v_addr;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ----- rtl/r2i_front.sv -----
// Front end: pixel intake, raster counters and plane address generation.
module r2i_front
    import r2i_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    input  cfg_t              cfg,
    input  q_stat_t           q_stat,
    output logic              push,
    output entry_t            entry
);

    localparam int SIZE_WW = $clog2(MAX_WIDTH + 1);
    localparam int SIZE_HW = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int LUMA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CHR_W   = LUMA_W - 2;
    localparam int AREA_W  = SIZE_WW + SIZE_HW;
    localparam int SUM_W   = AREA_W + 1;
    localparam int EWW     = (SIZE_WW > CFG_W) ? SIZE_WW : CFG_W;
    localparam int EHW     = (SIZE_HW > CFG_W) ? SIZE_HW : CFG_W;
    localparam logic [EWW-1:0] BOUND_W = EWW'(MAX_WIDTH & ~1);
    localparam logic [EHW-1:0] BOUND_H = EHW'(MAX_HEIGHT & ~1);
    localparam logic [1:0] SETTLE = 2'd2;

    logic [EWW-1:0]     raw_w;
    logic [EHW-1:0]     raw_h;
    logic [EWW-1:0]     clamp_w;
    logic [EHW-1:0]     clamp_h;
    logic [SIZE_WW-1:0] eff_w;
    logic [SIZE_HW-1:0] eff_h;

    logic [AREA_W-1:0]  area_reg;
    logic [SUM_W-1:0]   vbase_reg;
    logic [1:0]         settle_reg;
    logic [1:0]         settle_next;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [LUMA_W-1:0]  luma_reg;
    logic [LUMA_W-1:0]  luma_next;
    logic [CHR_W-1:0]   chr_reg;
    logic [CHR_W-1:0]   chr_next;

    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic               row_end;
    logic               frame_end;
    logic               chroma;
    logic               accept;

    // low bit dropped, then clamp to [2, bound]
    assign raw_w   = EWW'({cfg.width[CFG_W-1:1], 1'b0});
    assign raw_h   = EHW'({cfg.height[CFG_W-1:1], 1'b0});
    assign clamp_w = (raw_w < EWW'(2)) ? EWW'(2) : ((raw_w > BOUND_W) ? BOUND_W : raw_w);
    assign clamp_h = (raw_h < EHW'(2)) ? EHW'(2) : ((raw_h > BOUND_H) ? BOUND_H : raw_h);
    assign eff_w   = SIZE_WW'(clamp_w);
    assign eff_h   = SIZE_HW'(clamp_h);

    // hold input while the queue is full, or until the area terms reflect the current sizes
    assign pix_stall = q_stat.full || (settle_reg != 2'd0);
    assign accept    = pix_valid && !pix_stall;
    assign push      = accept;

    assign col_inc   = (COL_W + 1)'(col_reg) + (COL_W + 1)'(1);
    assign row_inc   = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1);
    assign row_end   = col_inc >= (COL_W + 1)'(eff_w);
    assign frame_end = row_end && (row_inc >= (ROW_W + 1)'(eff_h));
    assign chroma    = !row_reg[0] && !col_reg[0];

    always_comb
    begin
        settle_next = settle_reg;
        if (cfg.wr)
        begin
            settle_next = SETTLE;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        luma_next = luma_reg;
        chr_next  = chr_reg;
        if (accept)
        begin
            luma_next = luma_reg + LUMA_W'(1);
            if (chroma)
            begin
                chr_next = chr_reg + CHR_W'(1);
            end
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next  = '0;
                    luma_next = '0;
                    chr_next  = '0;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE;
            col_reg    <= '0;
            row_reg    <= '0;
            luma_reg   <= '0;
            chr_reg    <= '0;
        end
        else
        begin
            settle_reg <= settle_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            luma_reg   <= luma_next;
            chr_reg    <= chr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg  <= AREA_W'(eff_w) * AREA_W'(eff_h);
        vbase_reg <= SUM_W'(area_reg) + SUM_W'(area_reg >> 2);
    end

    always_comb
    begin
        entry.red       = red;
        entry.green     = green;
        entry.blue      = blue;
        entry.chroma    = chroma;
        entry.luma_addr = ADDR_W'(luma_reg);
        entry.u_addr    = ADDR_W'(SUM_W'(area_reg) + SUM_W'(chr_reg));
        entry.v_addr    = ADDR_W'(vbase_reg + SUM_W'(chr_reg));
    end

endmodule

// ----- rtl/r2i_queue.sv -----
// Short register queue between the front and back ends.
module r2i_queue
    import r2i_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  wdata,
    input  logic    pop,
    output entry_t  rdata,
    output q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign rdata      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> !pop)
        else $error("queue read while empty");
`endif

endmodule

// ----- rtl/r2i_back.sv -----
// Back end: color conversion and serialization of Y, U and V words.
module r2i_back
    import r2i_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  entry_t             head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [PLANE_W-1:0] plane,
    output logic [ADDR_W-1:0]  byte_address,
    output logic [COMP_W-1:0]  sample_value,
    output logic               last_of_pixel
);

    localparam int SUM_W = 18;

    logic [1:0]              idx_reg;
    logic [1:0]              idx_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic [PLANE_W-1:0]      plane_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [COMP_W-1:0]       value_reg;
    logic                    last_reg;

    logic                    load;
    logic                    take;
    logic                    last_word;
    logic signed [SUM_W-1:0] r_s;
    logic signed [SUM_W-1:0] g_s;
    logic signed [SUM_W-1:0] b_s;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] u_sum;
    logic signed [SUM_W-1:0] v_sum;
    logic [COMP_W-1:0]       y_byte;
    logic [COMP_W-1:0]       u_byte;
    logic [COMP_W-1:0]       v_byte;
    logic [PLANE_W-1:0]      sel_plane;
    logic [ADDR_W-1:0]       sel_addr;
    logic [COMP_W-1:0]       sel_value;

    assign r_s = $signed(SUM_W'(head.red));
    assign g_s = $signed(SUM_W'(head.green));
    assign b_s = $signed(SUM_W'(head.blue));

    assign y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s;
    // offset by 128 * 256 so the floor shift becomes a plain bit slice
    assign u_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd32768;
    assign v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd32768;

    assign y_byte = y_sum[15:8] + COMP_W'(16);
    assign u_byte = u_sum[15:8];
    assign v_byte = v_sum[15:8];

    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                sel_plane = PLANE_Y;
                sel_addr  = head.luma_addr;
                sel_value = y_byte;
            end
            2'd1:
            begin
                sel_plane = PLANE_U;
                sel_addr  = head.u_addr;
                sel_value = u_byte;
            end
            default:
            begin
                sel_plane = PLANE_V;
                sel_addr  = head.v_addr;
                sel_value = v_byte;
            end
        endcase
    end

    assign load      = !valid_reg || !res_stall;
    assign take      = load && !q_stat.empty;
    assign last_word = !head.chroma || (idx_reg == 2'd2);
    assign pop       = take && last_word;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !q_stat.empty;
        end
        if (take)
        begin
            idx_next = last_word ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            plane_reg <= sel_plane;
            addr_reg  <= sel_addr;
            value_reg <= sel_value;
            last_reg  <= last_word;
        end
    end

    assign res_valid     = valid_reg;
    assign plane         = plane_reg;
    assign byte_address  = addr_reg;
    assign sample_value  = value_reg;
    assign last_of_pixel = last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("word index out of range");
    a_u_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && plane_reg != PLANE_V) |-> (last_reg == (plane_reg == PLANE_Y ?
            last_reg : 1'b0)))
        else $error("U word marked last of pixel");
    a_v_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && plane_reg == PLANE_V) |-> last_reg)
        else $error("V word not marked last of pixel");
`endif

endmodule

// ----- rtl/rgba_to_i420_converter.sv -----
// Top level of the RGB to I420 converter: register port, front, queue and back.
//
//  channel  direction  handshake            payload
//  pixel    in         pix_valid/pix_stall  red, green, blue
//  result   out        res_valid/res_stall  plane, byte_address, sample_value, last_of_pixel
//  config   in         APB psel/penable     paddr, pwdata, prdata (0: width, 4: height)
//
// A pixel on an odd row or odd column yields only a Y word on the result port, a pixel
// at an even row and even column three words (Y, U, V).
// After reset and after every register write, pixel input stalls while the frame
// area and chroma base are recomputed.
// A four-pixel queue lets the pixel side keep accepting, until it fills, while results wait.
module rgba_to_i420_converter
    import r2i_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  logic [COMP_W-1:0]  red,
    input  logic [COMP_W-1:0]  green,
    input  logic [COMP_W-1:0]  blue,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [PLANE_W-1:0] plane,
    output logic [ADDR_W-1:0]  byte_address,
    output logic [COMP_W-1:0]  sample_value,
    output logic               last_of_pixel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             wr_en;
    cfg_t             cfg;
    q_stat_t          q_stat;
    logic             push;
    logic             pop;
    entry_t           wr_entry;
    entry_t           head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.wr     = wr_en;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    r2i_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .push      (push),
        .entry     (wr_entry)
    );

    r2i_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wr_entry),
        .pop   (pop),
        .rdata (head),
        .stat  (q_stat)
    );

    r2i_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .plane         (plane),
        .byte_address  (byte_address),
        .sample_value  (sample_value),
        .last_of_pixel (last_of_pixel)
    );

endmodule
